/* sv/dda_line_rasterizer_core_macros.svh */
// assertion macros for the line rasterizer checker
`ifndef DDA_LINE_RASTERIZER_CORE_MACROS_SVH
`define DDA_LINE_RASTERIZER_CORE_MACROS_SVH

// clocked check, switched off while reset is held
`define DLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define DLR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/dlr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dlr_pkg;

  // coordinate and fixed-point widths
  localparam int COORD_BITS = 11;
  localparam int FRAC_BITS  = 16;
  localparam int POS_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int INC_BITS   = FRAC_BITS + 2;
  localparam int CNT_BITS   = COORD_BITS + 1;

  // divider: numerator is |d| * 2^FRAC_BITS + steps / 2, quotient at most 2^FRAC_BITS
  localparam int NUM_BITS   = COORD_BITS + FRAC_BITS;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // one half in position format, for round half up
  localparam logic [POS_BITS-1:0] POS_HALF = POS_BITS'(1) << (FRAC_BITS - 1);

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic div_run;
    logic div_finish;
  } dlr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic steps_zero;
    logic line_done;
    logic skid_full;
  } dlr_stat_t;

endpackage

`default_nettype wire

/* sv/dlr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlr_datapath import dlr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dlr_cmd_t                     cmd,
  output dlr_stat_t                    stat,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_last_pixel
);

  // endpoint deltas, magnitudes and step count
  logic signed [COORD_BITS:0]   dx, dy, dx_neg, dy_neg;
  logic [COORD_BITS-1:0]        ax, ay, steps;
  logic [NUM_BITS-1:0]          num_x, num_y;

  always_comb begin
    dx     = {in_end_x[COORD_BITS-1], in_end_x} - {in_start_x[COORD_BITS-1], in_start_x};
    dy     = {in_end_y[COORD_BITS-1], in_end_y} - {in_start_y[COORD_BITS-1], in_start_y};
    dx_neg = -dx;
    dy_neg = -dy;
    ax     = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ay     = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    steps  = (ax >= ay) ? ax : ay;
    num_x  = {ax, {FRAC_BITS{1'b0}}} + NUM_BITS'(steps >> 1);
    num_y  = {ay, {FRAC_BITS{1'b0}}} + NUM_BITS'(steps >> 1);
  end

  // restoring divider, two lanes sharing the divisor
  logic [COORD_BITS-1:0] div_r;
  logic [COORD_BITS-1:0] rem_x_r, rem_y_r, rem_x_nxt, rem_y_nxt;
  logic [DIV_STEPS-1:0]  quo_x_r, quo_y_r, quo_x_nxt, quo_y_nxt;
  logic                  neg_x_r, neg_y_r;
  logic [COORD_BITS:0]   trial_x, trial_y, diff_x, diff_y;
  logic                  ge_x, ge_y;
  logic [INC_BITS-1:0]   q_x, q_y, inc_x, inc_y;

  always_comb begin
    trial_x   = {rem_x_r, quo_x_r[DIV_STEPS-1]};
    trial_y   = {rem_y_r, quo_y_r[DIV_STEPS-1]};
    diff_x    = trial_x - {1'b0, div_r};
    diff_y    = trial_y - {1'b0, div_r};
    ge_x      = trial_x >= {1'b0, div_r};
    ge_y      = trial_y >= {1'b0, div_r};
    rem_x_nxt = ge_x ? diff_x[COORD_BITS-1:0] : trial_x[COORD_BITS-1:0];
    rem_y_nxt = ge_y ? diff_y[COORD_BITS-1:0] : trial_y[COORD_BITS-1:0];
    quo_x_nxt = {quo_x_r[DIV_STEPS-2:0], ge_x};
    quo_y_nxt = {quo_y_r[DIV_STEPS-2:0], ge_y};
    q_x       = {1'b0, quo_x_nxt};
    q_y       = {1'b0, quo_y_nxt};
    inc_x     = neg_x_r ? -q_x : q_x;
    inc_y     = neg_y_r ? -q_y : q_y;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_r   <= steps;
      rem_x_r <= {1'b0, num_x[NUM_BITS-1:DIV_STEPS]};
      rem_y_r <= {1'b0, num_y[NUM_BITS-1:DIV_STEPS]};
      quo_x_r <= num_x[DIV_STEPS-1:0];
      quo_y_r <= num_y[DIV_STEPS-1:0];
      neg_x_r <= dx[COORD_BITS];
      neg_y_r <= dy[COORD_BITS];
    end else if (cmd.div_run) begin
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      quo_x_r <= quo_x_nxt;
      quo_y_r <= quo_y_nxt;
    end
  end

  // line state: position, increments, pixels still to emit
  logic [POS_BITS-1:0] pos_x_r, pos_y_r;
  logic [INC_BITS-1:0] step_x_r, step_y_r;
  logic [CNT_BITS-1:0] left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      step_x_r <= '0;
      step_y_r <= '0;
      left_r   <= '0;
    end else if (cmd.load) begin
      pos_x_r  <= {in_start_x[COORD_BITS-1], in_start_x, {FRAC_BITS{1'b0}}};
      pos_y_r  <= {in_start_y[COORD_BITS-1], in_start_y, {FRAC_BITS{1'b0}}};
      step_x_r <= '0;
      step_y_r <= '0;
      left_r   <= {1'b0, steps};
    end else if (cmd.div_finish) begin
      step_x_r <= inc_x;
      step_y_r <= inc_y;
    end else if (cmd.step) begin
      pos_x_r  <= pos_x_r + {{(POS_BITS-INC_BITS){step_x_r[INC_BITS-1]}}, step_x_r};
      pos_y_r  <= pos_y_r + {{(POS_BITS-INC_BITS){step_y_r[INC_BITS-1]}}, step_y_r};
      left_r   <= left_r - CNT_BITS'(1);
    end
  end

  // current pixel, rounded half up
  logic [POS_BITS-1:0]   sum_x, sum_y;
  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic                  pix_last;

  always_comb begin
    sum_x    = pos_x_r + POS_HALF;
    sum_y    = pos_y_r + POS_HALF;
    pix_x    = sum_x[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
    pix_y    = sum_y[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
    pix_last = (left_r == CNT_BITS'(1));
  end

  // output register plus skid word
  logic                  out_valid_r, skid_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r, skid_x_r, skid_y_r;
  logic                  out_last_r, skid_last_r;
  logic                  out_take;

  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (cmd.step) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (out_valid_r && !out_take) begin
        skid_x_r    <= pix_x;
        skid_y_r    <= pix_y;
        skid_last_r <= pix_last;
      end else begin
        out_x_r    <= pix_x;
        out_y_r    <= pix_y;
        out_last_r <= pix_last;
      end
    end else if (out_take && skid_valid_r) begin
      out_x_r    <= skid_x_r;
      out_y_r    <= skid_y_r;
      out_last_r <= skid_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = $signed(out_x_r);
  assign out_pixel_y    = $signed(out_y_r);
  assign out_last_pixel = out_last_r;

  // status back to the controller
  assign stat.steps_zero = (steps == '0);
  assign stat.line_done  = (left_r == '0);
  assign stat.skid_full  = skid_valid_r;

endmodule

`default_nettype wire

/* sv/dlr_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlr_controller import dlr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_operation,
  input  dlr_stat_t stat,
  output dlr_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_DIVIDE = 2'b10
  } dlr_state_t;

  dlr_state_t            state_r, state_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  accept;

  // input handshake
  assign in_stall = (state_r != ST_IDLE) || stat.skid_full;
  assign accept   = in_valid && !in_stall;

  // commands
  always_comb begin
    cmd.load       = accept && (in_operation == OP_LOAD);
    cmd.step       = accept && (in_operation == OP_STEP) && !stat.line_done;
    cmd.div_run    = (state_r == ST_DIVIDE);
    cmd.div_finish = (state_r == ST_DIVIDE) && (cnt_r == DIV_LAST);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load && !stat.steps_zero) begin
          state_nxt = ST_DIVIDE;
          cnt_nxt   = '0;
        end
      end
      ST_DIVIDE: begin
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/dda_line_rasterizer_core.sv */
// channel   direction  words                                      handshake
// in_       input      operation, start_x, start_y, end_x, end_y  in_valid / in_stall
// out_      output     pixel_x, pixel_y, last_pixel               out_valid / out_stall
//
// a step word's pixel is registered on out_, or in the skid word if out_ is stalled
// a load word starts the shared restoring divider that forms both increments;
// in_stall is high while it runs
// a zero-length line skips the divider, so its load does not raise in_stall
// output register plus one skid word: one step still gets in while a pixel waits
// rst_n is synchronous, active low; it clears the line and any pending pixels
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer_core import dlr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_last_pixel
);

  dlr_cmd_t  cmd;
  dlr_stat_t stat;

  // sequencing
  dlr_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd)
  );

  // arithmetic and output staging
  dlr_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

endmodule

`default_nettype wire

/* sv/dlr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "dda_line_rasterizer_core_macros.svh"

module dlr_checker import dlr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  in_operation,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_pixel_x,
  input logic [COORD_BITS-1:0] out_pixel_y,
  input logic                  out_last_pixel
);

  // handshake terms and the output word as one vector
  logic                      in_take, step_take, load_take, out_held;
  logic [2*COORD_BITS:0]     out_word;

  assign in_take   = in_valid && !in_stall;
  assign step_take = in_take && (in_operation == OP_STEP);
  assign load_take = in_take && (in_operation == OP_LOAD);
  assign out_held  = out_valid && out_stall;
  assign out_word  = {out_pixel_x, out_pixel_y, out_last_pixel};

  // a stalled output word holds
  `DLR_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_word), "held word changed")

  // a new output word only follows an accepted step word
  `DLR_ASSERT(a_out_from_step, $rose(out_valid) |-> $past(step_take), "word without a step")

  // a load never produces an output word
  `DLR_ASSERT(a_load_silent, load_take && !out_valid |=> !out_valid, "load produced a word")

  // reset empties the output side
  `DLR_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind dda_line_rasterizer_core dlr_checker u_dlr_checker (.*);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import dlr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AFTER  = 150;
  localparam int SETTLE      = 40;
  localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic   op;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } line_word_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   in_operation = OP_LOAD;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_last_pixel;

  line_word_t words_to_send[$];
  pixel_t     pixels_due[$];
  int         send_idle_pct = 23;
  int         recv_idle_pct = 47;
  int         failures = 0;
  int         cycle_count = 0;

  // predicted rasterizer state
  logic signed [POS_BITS-1:0] trace_x = '0;
  logic signed [POS_BITS-1:0] trace_y = '0;
  logic signed [INC_BITS-1:0] slope_x = '0;
  logic signed [INC_BITS-1:0] slope_y = '0;
  logic [CNT_BITS-1:0]        pixels_to_go = '0;

  dda_line_rasterizer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // fixed-point increment, delta scaled by 2^FRAC_BITS over the span, ties away from zero
  function automatic longint scaled_slope(longint delta, longint span);
    longint mag;
    longint q;
    mag = (delta < 0) ? -delta : delta;
    q = ((mag << FRAC_BITS) + span / 2) / span;
    return (delta < 0) ? -q : q;
  endfunction

  // floor(position + 0.5), wrapped to the coordinate width
  function automatic coord_t nearest_pixel(logic signed [POS_BITS-1:0] pos);
    longint v;
    v = longint'(pos) + (longint'(1) << (FRAC_BITS - 1));
    return coord_t'(v >>> FRAC_BITS);
  endfunction

  // update the predicted line state for one accepted word
  function automatic void rasterize_word(line_word_t w);
    longint dx;
    longint dy;
    longint ax;
    longint ay;
    longint span;
    pixel_t p;
    if (w.op == OP_LOAD) begin
      dx = longint'(w.ex) - longint'(w.sx);
      dy = longint'(w.ey) - longint'(w.sy);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      span = (ax >= ay) ? ax : ay;
      trace_x = POS_BITS'(longint'(w.sx) <<< FRAC_BITS);
      trace_y = POS_BITS'(longint'(w.sy) <<< FRAC_BITS);
      if (span == 0) begin
        slope_x = '0;
        slope_y = '0;
      end else begin
        slope_x = INC_BITS'(scaled_slope(dx, span));
        slope_y = INC_BITS'(scaled_slope(dy, span));
      end
      pixels_to_go = CNT_BITS'(span);
    end else if (pixels_to_go != 0) begin
      p.x = nearest_pixel(trace_x);
      p.y = nearest_pixel(trace_y);
      p.last = (pixels_to_go == 1);
      pixels_due.push_back(p);
      trace_x = trace_x + slope_x;
      trace_y = trace_y + slope_y;
      pixels_to_go = pixels_to_go - 1'b1;
    end
  endfunction

  // input driver
  always @(posedge clk) begin : driver
    line_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = words_to_send.pop_front();
        in_valid     <= 1'b1;
        in_operation <= w.op;
        in_start_x   <= w.sx;
        in_start_y   <= w.sy;
        in_end_x     <= w.ex;
        in_end_y     <= w.ey;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output receiver, with one long hold-off once traffic is flowing
  always @(posedge clk) begin : receiver
    int taken;
    int hold_left;
    bit hold_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      taken = 0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (out_valid && !out_stall)
        taken++;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && taken >= HOLD_AFTER) begin
        hold_done = 1;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // predict on accepted words, check accepted pixels
  always @(posedge clk) begin : monitor
    line_word_t w;
    pixel_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        w.op = in_operation;
        w.sx = in_start_x;
        w.sy = in_start_y;
        w.ex = in_end_x;
        w.ey = in_end_y;
        rasterize_word(w);
      end
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel: x %0d y %0d last %0b",
                 out_pixel_x, out_pixel_y, out_last_pixel);
          failures++;
        end else begin
          want = pixels_due.pop_front();
          if (out_pixel_x !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, out_pixel_x);
            failures++;
          end
          if (out_pixel_y !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, out_pixel_y);
            failures++;
          end
          if (out_last_pixel !== want.last) begin
            $error("last_pixel: expected %0b, got %0b", want.last, out_last_pixel);
            failures++;
          end
        end
      end
    end
  end

  function automatic void queue_word(logic op, int sx, int sy, int ex, int ey);
    line_word_t w;
    w.op = op;
    w.sx = coord_t'(sx);
    w.sy = coord_t'(sy);
    w.ex = coord_t'(ex);
    w.ey = coord_t'(ey);
    words_to_send.push_back(w);
  endfunction

  // step word, endpoint fields are don't-care so fill them with noise
  function automatic void queue_step();
    queue_word(OP_STEP, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic int clamp_coord(int v);
    return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // random lines: mostly a load followed by its steps, plus noise and cut lines
  task automatic queue_line_traffic(input int quota);
    int produced;
    int live;
    int pick;
    int n;
    int span;
    int sx, sy, ex, ey;
    int ax, ay;
    produced = 0;
    live = 0;
    while (produced < quota) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // stray steps, often past the end of the line
        n = $urandom_range(1, 4);
        repeat (n) begin
          queue_step();
          if (live > 0) begin
            live--;
            produced++;
          end
        end
      end else begin
        sx = $urandom_range(COORD_MAX - COORD_MIN) + COORD_MIN;
        sy = $urandom_range(COORD_MAX - COORD_MIN) + COORD_MIN;
        if (pick < 20) begin
          ex = $urandom_range(COORD_MAX - COORD_MIN) + COORD_MIN;
          ey = $urandom_range(COORD_MAX - COORD_MIN) + COORD_MIN;
        end else begin
          ex = clamp_coord(sx + $urandom_range(32) - 16);
          ey = clamp_coord(sy + $urandom_range(32) - 16);
        end
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        span = (ax >= ay) ? ax : ay;
        // long lines are only partly drawn before the next load replaces them
        if (span > 48)
          n = $urandom_range(1, 48);
        else if (pick < 30)
          n = $urandom_range(span);
        else
          n = span + $urandom_range(2);
        queue_word(OP_LOAD, sx, sy, ex, ey);
        produced++;
        live = span;
        repeat (n) begin
          queue_step();
          if (live > 0) begin
            live--;
            produced++;
          end
        end
      end
    end
  endtask

  // wait until every word is taken and every pixel has come back
  task automatic drain();
    while (words_to_send.size() != 0 || in_valid)
      @(negedge clk);
    while (pixels_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: step with no line loaded
    queue_step();
    // zero-length line draws nothing
    queue_word(OP_LOAD, 3, -2, 3, -2);
    queue_step();
    // full-range diagonal, cut short by a reversed one
    queue_word(OP_LOAD, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    repeat (3) queue_step();
    queue_word(OP_LOAD, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    repeat (2) queue_step();
    // half-pixel y positions round up, then a step past the end
    queue_word(OP_LOAD, 0, 0, 4, 2);
    repeat (5) queue_step();
    // negative half-pixel positions
    queue_word(OP_LOAD, 0, 0, -4, -2);
    repeat (4) queue_step();
    // vertical line going down
    queue_word(OP_LOAD, 5, 0, 5, -3);
    repeat (3) queue_step();
    drain();

    // random traffic, changing who idles
    queue_line_traffic(250);
    drain();
    send_idle_pct = 47;
    recv_idle_pct = 23;
    queue_line_traffic(250);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_line_traffic(250);
    drain();

    repeat (SETTLE) @(negedge clk);
    if (failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
